FILE: rtl/fluc_pkg.sv
// Shared widths, codes and control/status types for the frame luma usability check.
package fluc_pkg;

    localparam int LUMA_W      = 8;
    localparam int MEAN_W      = 8;
    localparam int VERDICT_W   = 2;
    localparam int TOTAL_W     = 30;
    localparam int IDX_W       = 22;
    localparam int LEN_W       = 23;
    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 23;
    localparam int LIMIT_W     = 8;
    localparam int DIV_STEPS   = 8;
    localparam int STEP_W      = 3;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 24;
    localparam int OUT_PAD_W   = OUT_TDATA_W - VERDICT_W - 2 * MEAN_W;

    localparam logic [LEN_W-1:0]   MAX_PIXELS       = 23'd4194304;
    localparam logic [LEN_W-1:0]   FRAME_PIXELS_RST = 23'd307200;
    localparam logic [LIMIT_W-1:0] BRIGHT_RST       = 8'hF0;
    localparam logic [LIMIT_W-1:0] DARK_RST         = 8'd16;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_PIXELS = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_BRIGHT_LIMIT = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_DARK_LIMIT   = 2'd2;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_UNIFORM = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_USABLE  = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_RANGE   = 2'd2;

    typedef struct packed {
        logic accept;     // input beat taken this cycle
        logic div_start;  // launch a mean division
        logic apply_half; // division done: store half mean if pending
        logic finish;     // load result, clear frame state
    } t_fluc_cmd;

    typedef struct packed {
        logic need_div;   // next beat hits midpoint or frame end
        logic pend_end;   // running division closes the frame
        logic div_done;   // quotient ready
        logic out_free;   // output register can load
    } t_fluc_stat;

endpackage

FILE: rtl/fluc_div.sv
// Iterative restoring divider: 8-bit quotient of a 30-bit sum by a 23-bit count.
module fluc_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [fluc_pkg::TOTAL_W-1:0] i_dividend,
    input  logic [fluc_pkg::LEN_W-1:0]   i_divisor,
    output logic                         o_done,
    output logic [fluc_pkg::MEAN_W-1:0]  o_quotient
);

    logic                         r_busy;
    logic                         r_done;
    logic [fluc_pkg::STEP_W-1:0]  r_step;
    logic [fluc_pkg::TOTAL_W-1:0] r_rem;
    logic [fluc_pkg::TOTAL_W-1:0] r_dsr;
    logic [fluc_pkg::MEAN_W-1:0]  r_q;
    logic [fluc_pkg::TOTAL_W:0]   diff;
    logic                         ge;

    always_comb begin
        diff = {1'b0, r_rem} - {1'b0, r_dsr};
        ge   = ~diff[fluc_pkg::TOTAL_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == fluc_pkg::STEP_W'(fluc_pkg::DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // quotient is known to fit 8 bits (sum <= 255 * count), so start at bit 7
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_dividend;
            r_dsr <= {i_divisor, {(fluc_pkg::DIV_STEPS - 1){1'b0}}};
            r_q   <= '0;
        end else if (r_busy) begin
            if (ge) begin
                r_rem <= diff[fluc_pkg::TOTAL_W-1:0];
            end
            r_dsr <= r_dsr >> 1;
            r_q   <= {r_q[fluc_pkg::MEAN_W-2:0], ge};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_q;

endmodule

FILE: rtl/fluc_dp.sv
// Datapath: config registers, running sum and index, mean divider, result register.
module fluc_dp (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fluc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fluc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic [fluc_pkg::LUMA_W-1:0]      i_luma,
    input  fluc_pkg::t_fluc_cmd              i_cmd,
    output fluc_pkg::t_fluc_stat             o_stat,
    input  logic                             i_out_ready,
    output logic                             o_out_valid,
    output logic [fluc_pkg::OUT_TDATA_W-1:0] o_out_data
);

    logic [fluc_pkg::LEN_W-1:0]       r_frame_pixels;
    logic [fluc_pkg::LIMIT_W-1:0]     r_bright;
    logic [fluc_pkg::LIMIT_W-1:0]     r_dark;
    logic [fluc_pkg::TOTAL_W-1:0]     r_total;
    logic [fluc_pkg::IDX_W-1:0]       r_idx;
    logic [fluc_pkg::MEAN_W-1:0]      r_half;
    logic                             r_pend_half;
    logic                             r_pend_end;
    logic                             r_out_valid;
    logic [fluc_pkg::OUT_TDATA_W-1:0] r_out_data;

    logic [fluc_pkg::LEN_W-1:0]     len;
    logic [fluc_pkg::LEN_W-1:0]     count;
    logic [fluc_pkg::TOTAL_W-1:0]   sum;
    logic                           is_half;
    logic                           is_end;
    logic                           div_done;
    logic [fluc_pkg::MEAN_W-1:0]    quot;
    logic [fluc_pkg::VERDICT_W-1:0] verdict;

    // effective frame length: zero means one sample, clamp to the maximum
    always_comb begin
        if (r_frame_pixels == '0) begin
            len = fluc_pkg::LEN_W'(1);
        end else if (r_frame_pixels > fluc_pkg::MAX_PIXELS) begin
            len = fluc_pkg::MAX_PIXELS;
        end else begin
            len = r_frame_pixels;
        end
        count   = {1'b0, r_idx} + 1'b1;
        sum     = r_total + fluc_pkg::TOTAL_W'(i_luma);
        is_half = (r_idx == len[fluc_pkg::LEN_W-1:1]);
        is_end  = (count >= len);
    end

    fluc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (sum),
        .i_divisor  (count),
        .o_done     (div_done),
        .o_quotient (quot)
    );

    always_comb begin
        if (quot == r_half) begin
            verdict = fluc_pkg::VERDICT_UNIFORM;
        end else if (quot < r_bright && quot > r_dark) begin
            verdict = fluc_pkg::VERDICT_USABLE;
        end else begin
            verdict = fluc_pkg::VERDICT_RANGE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_pixels <= fluc_pkg::FRAME_PIXELS_RST;
            r_bright       <= fluc_pkg::BRIGHT_RST;
            r_dark         <= fluc_pkg::DARK_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                fluc_pkg::REG_FRAME_PIXELS: r_frame_pixels <= i_cfg_wdata;
                fluc_pkg::REG_BRIGHT_LIMIT: r_bright <= i_cfg_wdata[fluc_pkg::LIMIT_W-1:0];
                fluc_pkg::REG_DARK_LIMIT:   r_dark   <= i_cfg_wdata[fluc_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total     <= '0;
            r_idx       <= '0;
            r_half      <= '0;
            r_pend_half <= 1'b0;
            r_pend_end  <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_total     <= sum;
                r_idx       <= count[fluc_pkg::IDX_W-1:0];
                r_pend_half <= is_half;
                r_pend_end  <= is_end;
            end
            if (i_cmd.apply_half && r_pend_half) begin
                r_half <= quot;
            end
            if (i_cmd.finish) begin
                r_total <= '0;
                r_idx   <= '0;
                r_half  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= {{fluc_pkg::OUT_PAD_W{1'b0}}, r_half, quot, verdict};
        end
    end

    always_comb begin
        o_stat.need_div = is_half | is_end;
        o_stat.pend_end = r_pend_end;
        o_stat.div_done = div_done;
        o_stat.out_free = ~r_out_valid | i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

FILE: rtl/fluc_ctrl.sv
// Controller: takes samples, holds the input while a mean division runs, issues the result.
module fluc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  fluc_pkg::t_fluc_stat i_stat,
    output fluc_pkg::t_fluc_cmd  o_cmd
);

    localparam logic [1:0] S_RUN = 2'd0;
    localparam logic [1:0] S_DIV = 2'd1;
    localparam logic [1:0] S_FIN = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_in_ready = (r_state == S_RUN);
    assign accept     = i_in_valid & o_in_ready;

    always_comb begin
        n_state          = r_state;
        o_cmd.accept     = accept;
        o_cmd.div_start  = accept & i_stat.need_div;
        o_cmd.apply_half = 1'b0;
        o_cmd.finish     = 1'b0;
        unique case (r_state)
            S_RUN: begin
                if (accept && i_stat.need_div) begin
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.apply_half = 1'b1;
                    n_state = i_stat.pend_end ? S_FIN : S_RUN;
                end
            end
            S_FIN: begin
                // quotient stays in the divider until the result register frees up
                if (i_stat.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_RUN;
                end
            end
            default: n_state = S_RUN;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_RUN;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/frame_luma_usability_check_unit.sv
// Input stalls: a plain sample is taken without holding the input; the midpoint sample holds
// the input while its mean division runs; the last sample holds it while its division runs
// and until its result beat loads, which waits for the output register to be free.
// Throughput: one sample per cycle outside the mean divisions; the iterative divider runs two
// 8-step divisions per frame (one when the midpoint is the last sample) and holds the input.
// Reset (i_rst_n low, synchronous): config 307200 / 240 / 16, sum, index, half mean clear.
module frame_luma_usability_check_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [fluc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr,
    input  logic [fluc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [fluc_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // [7:0] luma
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [fluc_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // [1:0] verdict,
                                                            // [9:2] frame_mean,
                                                            // [17:10] first_half_mean
);

    fluc_pkg::t_fluc_cmd  cmd;
    fluc_pkg::t_fluc_stat stat;

    fluc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    fluc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_luma      (s_axis_tdata[fluc_pkg::LUMA_W-1:0]),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata)
    );

    a_stall_on_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> !s_axis_tready)
        else $error("input not held while division runs");

    a_done_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stat.div_done |-> !s_axis_tready)
        else $error("division finished while input was open");

    a_finish_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |=> m_axis_tvalid)
        else $error("result beat not presented after frame end");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.finish |-> (!m_axis_tvalid || m_axis_tready))
        else $error("pending result overwritten");

    a_verdict_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("reserved verdict code on output");

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the frame luma usability check: directed table, then random frames.
`timescale 1ns / 100ps

module tb_top;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PHASES    = 12;
    localparam int BEATS_PER_PHASE = 160;

    typedef struct packed {
        logic [fluc_pkg::VERDICT_W-1:0] verdict;
        logic [fluc_pkg::MEAN_W-1:0]    frame_mean;
        logic [fluc_pkg::MEAN_W-1:0]    half_mean;
    } t_luma_verdict;

    typedef enum logic {ROW_CFG, ROW_BEAT} t_row_kind;

    typedef struct {
        t_row_kind                       kind;
        logic [fluc_pkg::CFG_ADDR_W-1:0] addr;
        logic [fluc_pkg::CFG_DATA_W-1:0] value;
        bit                              typed;
        t_luma_verdict                   res;
    } t_stim_row;

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [fluc_pkg::CFG_ADDR_W-1:0]  i_cfg_addr;
    logic [fluc_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [fluc_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [fluc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    // predictor state
    logic [fluc_pkg::LEN_W-1:0]   len_reg;
    logic [fluc_pkg::LIMIT_W-1:0] bright_reg;
    logic [fluc_pkg::LIMIT_W-1:0] dark_reg;
    logic [63:0]                  luma_sum;
    int unsigned                  pixel_idx;
    logic [fluc_pkg::MEAN_W-1:0]  mid_mean;

    t_luma_verdict expected_verdicts[$];
    t_stim_row     stim_rows[$];

    int tx_idle_pct;
    int rx_stall_pct;
    int hold_requests;
    int mismatch_count;
    int quiet_cycles;

    frame_luma_usability_check_unit DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // returns 1 when the sample closes a frame
    function automatic bit accumulate_luma(input logic [fluc_pkg::LUMA_W-1:0] luma,
                                           output t_luma_verdict res);
        int unsigned eff;
        int unsigned cnt;
        logic [fluc_pkg::MEAN_W-1:0] mean;
        eff = (len_reg == '0) ? 32'd1 :
              ((len_reg > fluc_pkg::MAX_PIXELS) ? 32'(fluc_pkg::MAX_PIXELS) : 32'(len_reg));
        luma_sum = luma_sum + 64'(luma);
        cnt = pixel_idx + 32'd1;
        res = '0;
        if (pixel_idx == eff / 2)
            mid_mean = fluc_pkg::MEAN_W'(luma_sum / 64'(cnt));
        if (cnt < eff) begin
            pixel_idx++;
            return 1'b0;
        end
        mean = fluc_pkg::MEAN_W'(luma_sum / 64'(cnt));
        if (mean == mid_mean)
            res.verdict = fluc_pkg::VERDICT_UNIFORM;
        else if (mean < bright_reg && mean > dark_reg)
            res.verdict = fluc_pkg::VERDICT_USABLE;
        else
            res.verdict = fluc_pkg::VERDICT_RANGE;
        res.frame_mean = mean;
        res.half_mean  = mid_mean;
        luma_sum  = '0;
        pixel_idx = 0;
        mid_mean  = '0;
        return 1'b1;
    endfunction

    function automatic void add_cfg(input logic [fluc_pkg::CFG_ADDR_W-1:0] addr,
                                    input logic [fluc_pkg::CFG_DATA_W-1:0] value);
        t_stim_row r;
        r.kind  = ROW_CFG;
        r.addr  = addr;
        r.value = value;
        r.typed = 1'b0;
        r.res   = '0;
        stim_rows.push_back(r);
    endfunction

    function automatic void add_beat(input logic [fluc_pkg::LUMA_W-1:0] luma, input bit typed,
                                     input logic [fluc_pkg::VERDICT_W-1:0] verdict,
                                     input logic [fluc_pkg::MEAN_W-1:0] fm,
                                     input logic [fluc_pkg::MEAN_W-1:0] hm);
        t_stim_row r;
        r.kind  = ROW_BEAT;
        r.addr  = '0;
        r.value = fluc_pkg::CFG_DATA_W'(luma);
        r.typed = typed;
        r.res.verdict    = verdict;
        r.res.frame_mean = fm;
        r.res.half_mean  = hm;
        stim_rows.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, exp);
        mismatch_count++;
    endtask

    // called at a falling edge; returns at a falling edge with tvalid still high
    task automatic send_luma(input logic [fluc_pkg::LUMA_W-1:0] luma, input bit typed,
                             input t_luma_verdict typed_res);
        int gap;
        bit closes;
        t_luma_verdict res;
        gap = 0;
        while ($urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = luma;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        closes = accumulate_luma(luma, res);
        if (typed)
            expected_verdicts.push_back(typed_res);
        else if (closes)
            expected_verdicts.push_back(res);
        @(negedge i_clk);
    endtask

    // register write with the block drained; a partial frame may still be open
    task automatic set_reg(input logic [fluc_pkg::CFG_ADDR_W-1:0] addr,
                           input logic [fluc_pkg::CFG_DATA_W-1:0] value);
        s_axis_tvalid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_addr  = addr;
        i_cfg_wdata = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (addr)
            fluc_pkg::REG_FRAME_PIXELS: len_reg    = value;
            fluc_pkg::REG_BRIGHT_LIMIT: bright_reg = value[fluc_pkg::LIMIT_W-1:0];
            fluc_pkg::REG_DARK_LIMIT:   dark_reg   = value[fluc_pkg::LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    // receiver: random stalls plus an occasional long hold
    initial begin
        int hold_left;
        int hold_served;
        hold_left     = 0;
        hold_served   = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_requests) begin
                hold_served = hold_requests;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                m_axis_tready = 1'b0;
                hold_left--;
            end else begin
                m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        t_luma_verdict exp_res;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_verdicts.size() == 0) begin
                report_mismatch("unexpected verdict beat", int'(m_axis_tdata[1:0]), -1);
            end else begin
                exp_res = expected_verdicts.pop_front();
                if (m_axis_tdata[1:0] !== exp_res.verdict)
                    report_mismatch("verdict", int'(m_axis_tdata[1:0]),
                                    int'(exp_res.verdict));
                if (m_axis_tdata[9:2] !== exp_res.frame_mean)
                    report_mismatch("frame_mean", int'(m_axis_tdata[9:2]),
                                    int'(exp_res.frame_mean));
                if (m_axis_tdata[17:10] !== exp_res.half_mean)
                    report_mismatch("first_half_mean", int'(m_axis_tdata[17:10]),
                                    int'(exp_res.half_mean));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || i_cfg_we)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat accepted for %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        t_luma_verdict no_res;
        int            phase;
        int            k;
        int            pick;
        int            lo;
        int            hi;
        int            a;
        int            b;
        logic [fluc_pkg::LUMA_W-1:0] luma;

        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_addr     = '0;
        i_cfg_wdata    = '0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        tx_idle_pct    = 0;
        rx_stall_pct   = 0;
        hold_requests  = 0;
        no_res         = '0;
        len_reg    = fluc_pkg::FRAME_PIXELS_RST;
        bright_reg = fluc_pkg::BRIGHT_RST;
        dark_reg   = fluc_pkg::DARK_RST;
        luma_sum   = '0;
        pixel_idx  = 0;
        mid_mean   = '0;

        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // one-sample frames, then zero length which acts as one
        add_cfg(fluc_pkg::REG_FRAME_PIXELS, 23'd1);
        add_beat(8'd0,   1, fluc_pkg::VERDICT_UNIFORM, 8'd0,   8'd0);
        add_beat(8'd255, 1, fluc_pkg::VERDICT_UNIFORM, 8'd255, 8'd255);
        add_cfg(fluc_pkg::REG_FRAME_PIXELS, 23'd0);
        add_beat(8'd128, 1, fluc_pkg::VERDICT_UNIFORM, 8'd128, 8'd128);
        // three-sample frames under reset limits
        add_cfg(fluc_pkg::REG_FRAME_PIXELS, 23'd3);
        add_beat(8'd0,   0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd0,   0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd255, 1, fluc_pkg::VERDICT_USABLE,  8'd85, 8'd0);
        add_beat(8'd255, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd255, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd0,   1, fluc_pkg::VERDICT_USABLE,  8'd170, 8'd255);
        add_beat(8'd0,   0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd0,   0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd30,  1, fluc_pkg::VERDICT_RANGE,   8'd10, 8'd0);
        add_beat(8'd240, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd240, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd255, 1, fluc_pkg::VERDICT_RANGE,   8'd245, 8'd240);
        // widest usable window
        add_cfg(fluc_pkg::REG_BRIGHT_LIMIT, 23'd255);
        add_cfg(fluc_pkg::REG_DARK_LIMIT,   23'd0);
        add_beat(8'd0, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd0, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd6, 1, fluc_pkg::VERDICT_USABLE,  8'd2, 8'd0);
        // empty usable window
        add_cfg(fluc_pkg::REG_BRIGHT_LIMIT, 23'd0);
        add_cfg(fluc_pkg::REG_DARK_LIMIT,   23'd255);
        add_beat(8'd0, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd0, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd6, 1, fluc_pkg::VERDICT_RANGE,   8'd2, 8'd0);
        // oversized length saturates, then shrinks under an open frame
        add_cfg(fluc_pkg::REG_FRAME_PIXELS, 23'h7FFFFF);
        add_beat(8'd10, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd20, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_beat(8'd30, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);
        add_cfg(fluc_pkg::REG_FRAME_PIXELS, 23'd2);
        add_beat(8'd40, 0, fluc_pkg::VERDICT_UNIFORM, 8'd0, 8'd0);

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_CFG)
                set_reg(stim_rows[i].addr, stim_rows[i].value);
            else
                send_luma(stim_rows[i].value[fluc_pkg::LUMA_W-1:0], stim_rows[i].typed,
                          stim_rows[i].res);
        end

        // random phases; config changes land mid-frame as often as not
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase % 4)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 69; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 69; end
                default: begin tx_idle_pct = 18; rx_stall_pct = 18; end
            endcase
            pick = $urandom_range(0, 9);
            if (phase == 4)
                set_reg(fluc_pkg::REG_FRAME_PIXELS,
                        fluc_pkg::CFG_DATA_W'($urandom_range(1, 3)));
            else if (pick < 6)
                set_reg(fluc_pkg::REG_FRAME_PIXELS,
                        fluc_pkg::CFG_DATA_W'($urandom_range(1, 40)));
            else if (pick < 8)
                set_reg(fluc_pkg::REG_FRAME_PIXELS,
                        fluc_pkg::CFG_DATA_W'($urandom_range(41, 300)));
            else
                set_reg(fluc_pkg::REG_FRAME_PIXELS,
                        fluc_pkg::CFG_DATA_W'($urandom_range(0, 2)));
            if ($urandom_range(0, 3) == 0) begin
                set_reg(fluc_pkg::REG_BRIGHT_LIMIT,
                        fluc_pkg::CFG_DATA_W'($urandom_range(0, 255)));
                set_reg(fluc_pkg::REG_DARK_LIMIT,
                        fluc_pkg::CFG_DATA_W'($urandom_range(0, 255)));
            end else begin
                set_reg(fluc_pkg::REG_BRIGHT_LIMIT,
                        fluc_pkg::CFG_DATA_W'($urandom_range(160, 255)));
                set_reg(fluc_pkg::REG_DARK_LIMIT,
                        fluc_pkg::CFG_DATA_W'($urandom_range(0, 80)));
            end
            // long output hold with tiny frames: block backs up onto its input
            if (phase == 4)
                hold_requests++;
            lo = 0;
            hi = 255;
            for (k = 0; k < BEATS_PER_PHASE; k++) begin
                if (k % 40 == 0) begin
                    a  = $urandom_range(0, 255);
                    b  = $urandom_range(0, 255);
                    lo = (a < b) ? a : b;
                    hi = (a < b) ? b : a;
                    if ($urandom_range(0, 3) == 0)
                        hi = (lo + 3 > 255) ? 255 : lo + 3;
                end
                pick = $urandom_range(0, 15);
                if (pick == 0)
                    luma = 8'd0;
                else if (pick == 1)
                    luma = 8'd255;
                else if (pick == 2)
                    luma = fluc_pkg::LUMA_W'($urandom_range(0, 255));
                else
                    luma = fluc_pkg::LUMA_W'($urandom_range(lo, hi));
                send_luma(luma, 1'b0, no_res);
            end
        end

        s_axis_tvalid = 1'b0;
        while (expected_verdicts.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
